/* hw/rtl/order_statistic_count_tree_assert.svh */
// Assertion macros for the order statistic count tree RTL.
// Depends on nothing; modules include it and supply clk and arst_n in scope.
`ifndef ORDER_STATISTIC_COUNT_TREE_ASSERT_SVH
`define ORDER_STATISTIC_COUNT_TREE_ASSERT_SVH
`ifndef SYNTHESIS
// Check an expression at every clock edge out of reset.
`define OSCT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Check a same-cycle implication out of reset.
`define OSCT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define OSCT_ASSERT_ALWAYS(lbl, expr, msg)
`define OSCT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/osct_pkg.sv */
// Package for the order statistic count tree: sizes, codes and the microcode ROM.
// Depends on nothing; used by order_statistic_count_tree and its testbench.
package osct_pkg;

	// Tree size; NUM_KEYS must be a power of two.
	localparam int NUM_KEYS   = 1024;
	localparam int NODE_SLOTS = 2 * NUM_KEYS;
	localparam int LEVELS     = $clog2(NUM_KEYS);

	// Field and storage widths.
	localparam int KEY_W  = 10;
	localparam int RANK_W = 31;
	localparam int AMT_W  = 16;
	localparam int CNT_W  = 32;
	localparam int ST_W   = 2;
	localparam int NODE_W = $clog2(NODE_SLOTS);
	localparam int LVL_W  = $clog2(LEVELS + 1);
	localparam int UPC_W  = 5;

	// Item action codes.
	localparam logic ACT_TAKE = 1'b0;
	localparam logic ACT_ADD  = 1'b1;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANK  = 2'd1,
		ST_COUNT = 2'd2
	} status_t;

	// Read port usage of one step.
	typedef enum logic [1:0] {
		RD_NONE,
		RD_ROOT,
		RD_NODE,
		RD_KIDS
	} rd_t;

	// Datapath operation of one step.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_WAIT,
		OP_INIT,
		OP_DEC_ROOT,
		OP_TAKE,
		OP_ADV,
		OP_ADD_ADV,
		OP_CHK_ROOT,
		OP_CHK_LEAF,
		OP_FIN
	} op_t;

	// Jump condition of one step.
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_ADD,
		COND_RANK_BAD,
		COND_KEY_BAD,
		COND_MORE,
		COND_NOT_LEAF,
		COND_BAD
	} cond_t;

	typedef struct packed {
		rd_t              rd;
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
		status_t          status;
	} ucode_t;

	// Step addresses.
	localparam logic [UPC_W-1:0] P_IDLE     = 5'd0;
	localparam logic [UPC_W-1:0] P_START    = 5'd1;
	localparam logic [UPC_W-1:0] P_TCHK     = 5'd2;
	localparam logic [UPC_W-1:0] P_TDEC     = 5'd3;
	localparam logic [UPC_W-1:0] P_TLOOP    = 5'd4;
	localparam logic [UPC_W-1:0] P_TSTEP    = 5'd5;
	localparam logic [UPC_W-1:0] P_TFIN     = 5'd6;
	localparam logic [UPC_W-1:0] P_ADD      = 5'd7;
	localparam logic [UPC_W-1:0] P_AWALK    = 5'd8;
	localparam logic [UPC_W-1:0] P_ALEAF    = 5'd9;
	localparam logic [UPC_W-1:0] P_ACHK     = 5'd10;
	localparam logic [UPC_W-1:0] P_ARESTART = 5'd11;
	localparam logic [UPC_W-1:0] P_ALOOP    = 5'd12;
	localparam logic [UPC_W-1:0] P_ASTEP    = 5'd13;
	localparam logic [UPC_W-1:0] P_AFIN     = 5'd14;
	localparam logic [UPC_W-1:0] P_FIN_RANK = 5'd15;
	localparam logic [UPC_W-1:0] P_FIN_CNT  = 5'd16;

	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] a);
		ucode_t w;
		w = '{rd: RD_NONE, op: OP_NONE, cond: COND_NEVER, target: P_IDLE, status: ST_OK};
		case (a)
			P_IDLE:     w.op = OP_WAIT;
			P_START:    begin
				w.rd = RD_ROOT; w.op = OP_INIT; w.cond = COND_ADD; w.target = P_ADD;
			end
			P_TCHK:     begin
				w.cond = COND_RANK_BAD; w.target = P_FIN_RANK;
			end
			P_TDEC:     w.op = OP_DEC_ROOT;
			P_TLOOP:    w.rd = RD_KIDS;
			P_TSTEP:    begin
				w.op = OP_TAKE; w.cond = COND_MORE; w.target = P_TLOOP;
			end
			P_TFIN:     begin
				w.op = OP_FIN; w.cond = COND_ALWAYS;
			end
			P_ADD:      begin
				w.op = OP_CHK_ROOT; w.cond = COND_KEY_BAD; w.target = P_FIN_RANK;
			end
			P_AWALK:    begin
				w.op = OP_ADV; w.cond = COND_MORE; w.target = P_AWALK;
			end
			P_ALEAF:    w.rd = RD_NODE;
			P_ACHK:     w.op = OP_CHK_LEAF;
			P_ARESTART: begin
				w.op = OP_INIT; w.cond = COND_BAD; w.target = P_FIN_CNT;
			end
			P_ALOOP:    w.rd = RD_NODE;
			P_ASTEP:    begin
				w.op = OP_ADD_ADV; w.cond = COND_NOT_LEAF; w.target = P_ALOOP;
			end
			P_AFIN:     begin
				w.op = OP_FIN; w.cond = COND_ALWAYS;
			end
			P_FIN_RANK: begin
				w.op = OP_FIN; w.cond = COND_ALWAYS; w.status = ST_RANK;
			end
			P_FIN_CNT:  begin
				w.op = OP_FIN; w.cond = COND_ALWAYS; w.status = ST_COUNT;
			end
			default:    w.cond = COND_ALWAYS;
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/order_statistic_count_tree.sv */
// Order statistic count tree: per-key counts in a preorder counting tree with a
// microcoded sequencer. Depends on osct_pkg and order_statistic_count_tree_assert.svh.
//
// Usage: the input channel (in_valid/in_ready) carries one item of action, rank, key
// and amount. An add item (action 1) changes the count of key by the signed amount;
// a take item (action 0) finds the key holding the item of the given 1-based rank,
// in ascending key order, and removes that one item. Each item gives exactly one
// result on the output channel (out_valid/out_ready): found_key and status.
// One item is worked at a time. Its pace is set by the single node memory: each tree
// level of a take, and of an add's update, needs a read step and a write step, and
// an add walks the path twice (check, then update).
// Reset: arst_n clears control state, then a clearing pass zeroes the 2*NUM_KEYS
// node counts, one entry per cycle; in_ready stays low meanwhile.
// Stall: the result sits in an output register, so the next item is accepted while
// it waits; that item then holds at its final step until the register frees up.
`include "order_statistic_count_tree_assert.svh"

module order_statistic_count_tree
	import osct_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    action,
	input  logic [RANK_W-1:0]       rank,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [AMT_W-1:0] amount,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [KEY_W-1:0]        found_key,
	output logic [ST_W-1:0]         status
);

	localparam logic [NODE_W-1:0] KEYS_N    = NODE_W'(NUM_KEYS);
	localparam logic [LVL_W-1:0]  LVL_LEAF  = LVL_W'(LEVELS);
	localparam logic [LVL_W-1:0]  LVL_LAST  = LVL_W'(LEVELS - 1);
	localparam logic [LVL_W-1:0]  LVL_ONE   = LVL_W'(1);
	localparam int                SUM_W     = CNT_W + 2;

	// Node memory: two read ports with registered data, one write port.
	logic [CNT_W-1:0]  mem [NODE_SLOTS];
	logic [CNT_W-1:0]  rd_a_q, rd_b_q;
	logic              rd_en_a, rd_en_b;
	logic [NODE_W-1:0] addr_a, addr_b;
	logic              mem_we;
	logic [NODE_W-1:0] mem_waddr;
	logic [CNT_W-1:0]  mem_wdata;

	// Clearing pass after reset.
	logic              clr_busy_q;
	logic [NODE_W-1:0] clr_q;

	// Sequencer.
	logic [UPC_W-1:0]  upc_q, upc_next;
	ucode_t            uw;
	logic              cond_hit, stall, in_acc;

	// Latched item.
	logic                    action_q;
	logic [RANK_W-1:0]       rank_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [AMT_W-1:0] amt_q;

	// Walk state.
	logic [NODE_W-1:0] node_q;
	logic [KEY_W-1:0]  lo_q;
	logic [LVL_W-1:0]  level_q;
	logic [CNT_W-1:0]  left_q;
	logic              bad_q;

	// Output register.
	logic              out_valid_q;
	logic [KEY_W-1:0]  found_q;
	status_t           status_q;

	// Per-level derived values.
	logic [NODE_W-1:0] rnode;
	logic [KEY_W-1:0]  half;
	logic              key_right, take_left, adv_ok, fin_go;
	logic [SUM_W-1:0]  amt_sext, root_sum, leaf_sum;
	logic [CNT_W-1:0]  amt_32;

	assign uw = ucode_rom(upc_q);

	// Right child sits one subtree width further on; half is the key span below.
	assign rnode     = node_q + (KEYS_N >> level_q);
	assign half      = KEY_W'(KEYS_N >> (level_q + LVL_ONE));
	assign key_right = key_q >= (lo_q + half);
	assign take_left = rd_a_q >= left_q;
	assign adv_ok    = level_q != LVL_LEAF;

	assign amt_sext  = {{(SUM_W - AMT_W){amt_q[AMT_W-1]}}, amt_q};
	assign amt_32    = amt_sext[CNT_W-1:0];
	assign root_sum  = {2'b00, rd_a_q} + amt_sext;
	assign leaf_sum  = {2'b00, rd_a_q} + amt_sext;

	assign in_ready  = (uw.op == OP_WAIT) && !clr_busy_q;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign found_key = found_q;
	assign status    = status_q;

	// Jump condition.
	always_comb begin
		case (uw.cond)
			COND_NEVER:    cond_hit = 1'b0;
			COND_ALWAYS:   cond_hit = 1'b1;
			COND_ADD:      cond_hit = (action_q == ACT_ADD);
			COND_RANK_BAD: cond_hit = (rank_q == '0) || ({1'b0, rank_q} > rd_a_q);
			COND_KEY_BAD:  cond_hit = {1'b0, key_q} >= (KEY_W + 1)'(NUM_KEYS);
			COND_MORE:     cond_hit = level_q != LVL_LAST;
			COND_NOT_LEAF: cond_hit = level_q != LVL_LEAF;
			COND_BAD:      cond_hit = bad_q;
			default:       cond_hit = 1'b0;
		endcase
	end

	// Hold at the wait step without an item, and at a final step while the
	// output register is full and not being drained.
	assign stall  = ((uw.op == OP_WAIT) && !in_acc)
	             || ((uw.op == OP_FIN) && out_valid_q && !out_ready);
	assign fin_go = (uw.op == OP_FIN) && !stall;

	always_comb begin
		if (stall)         upc_next = upc_q;
		else if (cond_hit) upc_next = uw.target;
		else               upc_next = upc_q + UPC_W'(1);
	end

	// Read port control.
	always_comb begin
		rd_en_a = 1'b0;
		rd_en_b = 1'b0;
		addr_a  = node_q;
		addr_b  = rnode;
		case (uw.rd)
			RD_NONE: ;
			RD_ROOT: begin
				rd_en_a = 1'b1;
				addr_a  = '0;
			end
			RD_NODE: rd_en_a = 1'b1;
			RD_KIDS: begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
				addr_a  = node_q + NODE_W'(1);
			end
			default: ;
		endcase
	end

	// Write port control; the clearing pass owns the port while it runs.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = rd_a_q + amt_32;
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			case (uw.op)
				OP_DEC_ROOT: begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = rd_a_q - CNT_W'(1);
				end
				OP_TAKE: begin
					mem_we    = 1'b1;
					mem_waddr = take_left ? (node_q + NODE_W'(1)) : rnode;
					mem_wdata = (take_left ? rd_a_q : rd_b_q) - CNT_W'(1);
				end
				OP_ADD_ADV: mem_we = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (rd_en_a) rd_a_q <= mem[addr_a];
		if (rd_en_b) rd_b_q <= mem[addr_b];
	end

	// Clear pass: sweep every node once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + NODE_W'(1);
			if (clr_q == NODE_W'(NODE_SLOTS - 1)) clr_busy_q <= 1'b0;
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) upc_q <= P_IDLE;
		else         upc_q <= upc_next;
	end

	// Latch the item on accept.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q <= action;
			rank_q   <= rank;
			key_q    <= key;
			amt_q    <= amount;
		end
	end

	// Walk state: descend by key (add) or by rank (take).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= '0;
			lo_q    <= '0;
			level_q <= '0;
			left_q  <= '0;
			bad_q   <= 1'b0;
		end else begin
			case (uw.op)
				OP_INIT: begin
					node_q  <= '0;
					lo_q    <= '0;
					level_q <= '0;
					left_q  <= {1'b0, rank_q};
				end
				OP_ADV, OP_ADD_ADV: begin
					if (adv_ok) begin
						node_q  <= key_right ? rnode : (node_q + NODE_W'(1));
						lo_q    <= key_right ? (lo_q + half) : lo_q;
						level_q <= level_q + LVL_ONE;
					end
				end
				OP_TAKE: begin
					if (take_left) begin
						node_q <= node_q + NODE_W'(1);
					end else begin
						node_q <= rnode;
						lo_q   <= lo_q + half;
						left_q <= left_q - rd_a_q;
					end
					level_q <= level_q + LVL_ONE;
				end
				// Root total must stay within 32 bits.
				OP_CHK_ROOT: bad_q <= !root_sum[SUM_W-1] && root_sum[CNT_W];
				// Leaf count must not go negative.
				OP_CHK_LEAF: bad_q <= bad_q || leaf_sum[SUM_W-1];
				default: ;
			endcase
		end
	end

	// Output register: load at a final step, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			status_q <= uw.status;
			found_q  <= (uw.status == ST_OK && action_q == ACT_TAKE) ? lo_q : '0;
		end
	end

	// No item enters while the clearing pass owns the memory.
	`OSCT_ASSERT_ALWAYS(a_no_accept_in_clear, !(clr_busy_q && in_ready), "item accepted during clear")
	// A take only ever decrements a node that holds a count.
	`OSCT_ASSERT_IMPL(a_take_nonzero, uw.op == OP_TAKE, (take_left ? rd_a_q : rd_b_q) != '0, "take underflow")
	// An add writes only after both range checks pass.
	`OSCT_ASSERT_IMPL(a_add_checked, uw.op == OP_ADD_ADV, !bad_q, "add written after failed check")
	// A result appears only from a final step.
	`OSCT_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_q), $past(uw.op == OP_FIN), "result without final step")

endmodule

/* tb/tb_order_statistic_count_tree.sv */
`timescale 1ns / 100ps
// Self-checking testbench for order_statistic_count_tree: directed and random add and
// take items, each result checked against a per-key count predictor. Depends on osct_pkg.
module tb_order_statistic_count_tree
	import osct_pkg::*;
();

	localparam int   HOT_KEYS = 8;
	// Length of the long receiver hold that backs the block up into its input.
	localparam int   HOLD_CYCLES = 400;

	typedef struct packed {
		logic [KEY_W-1:0] found;
		status_t          st;
	} tree_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    action;
	logic [RANK_W-1:0]       rank;
	logic [KEY_W-1:0]        key;
	logic signed [AMT_W-1:0] amount;
	logic                    out_valid;
	logic                    out_ready;
	logic [KEY_W-1:0]        found_key;
	logic [ST_W-1:0]         status;

	// Predictor state: one count per key and their sum, which the root node holds.
	longint           key_count[NUM_KEYS];
	longint           tree_total;
	longint           peak_total;
	logic [KEY_W-1:0] hot_keys[HOT_KEYS];

	tree_result_t expected_results[$];

	bit tx_quiet      = 1'b0;
	int hold_requests = 0;
	int fault_count   = 0;
	int results_seen  = 0;
	int adds_sent     = 0;
	int takes_sent    = 0;
	int ok_count      = 0;
	int rank_fails    = 0;
	int count_fails   = 0;

	always #5 clk = ~clk;

	order_statistic_count_tree u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.rank      (rank),
		.key       (key),
		.amount    (amount),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found_key (found_key),
		.status    (status)
	);

	// Apply one item to the predictor state and return the result it must produce.
	// A take walks keys in ascending order until the running count reaches the rank,
	// which picks the same leaf as a descent through the node sums. A total beyond
	// 32 bits would take over a hundred thousand large adds; the random mix stays below.
	function automatic tree_result_t apply_item(logic act, logic [RANK_W-1:0] r,
			logic [KEY_W-1:0] k, logic signed [AMT_W-1:0] amt);
		tree_result_t res;
		longint       running;
		longint       leaf_after;
		longint       total_after;
		int           i;
		res.found = '0;
		res.st    = ST_OK;
		if (act == ACT_TAKE) begin
			if (r == 0 || longint'(r) > tree_total) begin
				res.st = ST_RANK;
			end else begin
				running = 0;
				for (i = 0; i < NUM_KEYS && running < longint'(r); i++)
					running += key_count[i];
				res.found = KEY_W'(i - 1);
				key_count[i - 1]--;
				tree_total--;
			end
		end else if (int'(k) >= NUM_KEYS) begin
			res.st = ST_RANK;
		end else begin
			leaf_after  = key_count[k] + longint'(amt);
			total_after = tree_total + longint'(amt);
			if (leaf_after < 0 || total_after > 64'hFFFF_FFFF) begin
				res.st = ST_COUNT;
			end else begin
				key_count[k] = leaf_after;
				tree_total   = total_after;
				if (tree_total > peak_total)
					peak_total = tree_total;
			end
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	// Offer one item and hold it until the block takes it, then log its expected result.
	// Leave valid high; the caller decides whether a gap follows.
	task automatic send_item(logic act, logic [RANK_W-1:0] r, logic [KEY_W-1:0] k,
			logic signed [AMT_W-1:0] amt);
		tree_result_t want;
		in_valid <= 1'b1;
		action   <= act;
		rank     <= r;
		key      <= k;
		amount   <= amt;
		do @(posedge clk); while (!in_ready);
		want = apply_item(act, r, k, amt);
		expected_results = {expected_results, want};
		if (act == ACT_ADD)
			adds_sent++;
		else
			takes_sent++;
		case (want.st)
			ST_OK:    ok_count++;
			ST_RANK:  rank_fails++;
			default:  count_fails++;
		endcase
	endtask

	task automatic sender_pause(int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Unused fields carry junk so that the block is seen to ignore them.
	task automatic send_add(logic [KEY_W-1:0] k, logic signed [AMT_W-1:0] amt);
		send_item(ACT_ADD, RANK_W'($urandom), k, amt);
		sender_pause(pick_gap());
	endtask

	task automatic send_take(logic [RANK_W-1:0] r);
		send_item(ACT_TAKE, r, KEY_W'($urandom), AMT_W'($urandom));
		sender_pause(pick_gap());
	endtask

	// Mostly well-formed traffic on a few hot keys: grow counts, take existing ranks,
	// shrink within a count; the rest is noise: any key, ranks out of reach, zero or overdrawing adds.
	task automatic send_random_item();
		int                      sel;
		int                      lim;
		longint                  cnt;
		logic [KEY_W-1:0]        k;
		logic signed [AMT_W-1:0] amt;
		sel = $urandom_range(0, 99);
		k   = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
		cnt = key_count[k];
		if (sel < 34) begin
			if ($urandom_range(0, 9) == 0)
				amt = AMT_W'($urandom_range(1, 32767));
			else
				amt = AMT_W'($urandom_range(1, 12));
			send_add(k, amt);
		end else if (sel < 68) begin
			if (tree_total > 0)
				send_take(RANK_W'($urandom_range(1, 32'(tree_total))));
			else
				send_take(RANK_W'(1));
		end else if (sel < 78) begin
			if (cnt == 0) begin
				amt = -1;
			end else begin
				lim = (cnt > 32768) ? 32768 : int'(cnt);
				amt = AMT_W'(-longint'($urandom_range(1, lim)));
			end
			send_add(k, amt);
		end else if (sel < 88) begin
			send_add(KEY_W'($urandom), AMT_W'($urandom));
		end else if (sel < 95) begin
			case ($urandom_range(0, 2))
				0:       send_take('0);
				1:       send_take(RANK_W'(tree_total + 1));
				default: send_take(RANK_W'($urandom));
			endcase
		end else begin
			if (sel[0] || cnt >= 32768)
				send_add(k, '0);
			else
				send_add(k, AMT_W'(-(cnt + 1)));
		end
	endtask

	// Empty tree: every take has a bad rank, every removal would go negative.
	task automatic test_empty_tree();
		send_take(RANK_W'(1));
		send_take('0);
		send_take('1);
		send_add('0, -1);
		send_add(KEY_W'(NUM_KEYS - 1), 16'sh8000);
		send_add(KEY_W'(3), '0);
	endtask

	// Edge keys, full-scale amounts, ranks at the exact total, and the halves split.
	task automatic test_extremes();
		send_add('0, 1);
		send_add(KEY_W'(NUM_KEYS - 1), 16'sh7FFF);
		send_add(KEY_W'(NUM_KEYS - 1), 16'sh7FFF);
		send_add(KEY_W'(NUM_KEYS - 1), 16'sh8000);
		send_take(RANK_W'(1));
		send_take(RANK_W'(32766));
		send_take(RANK_W'(32766));
		send_add(KEY_W'(NUM_KEYS / 2 - 1), 2);
		send_add(KEY_W'(NUM_KEYS / 2), 2);
		send_take(RANK_W'(2));
		send_take(RANK_W'(2));
		send_take(RANK_W'(1));
		send_add(KEY_W'(NUM_KEYS / 2 - 1), -1);
	endtask

	task automatic test_random_traffic(int n);
		int j;
		for (j = 0; j < n; j++) begin
			if (j % 60 == 0)
				tx_quiet = ($urandom_range(0, 2) == 0);
			send_random_item();
		end
		tx_quiet = 1'b0;
	endtask

	// Hold the receiver off for a long stretch and keep offering items back to back:
	// the output register fills, then the block holds its input low.
	task automatic test_output_stall();
		int j;
		tx_quiet = 1'b1;
		hold_requests <= hold_requests + 1;
		for (j = 0; j < 8; j++)
			send_random_item();
		tx_quiet = 1'b0;
	endtask

	// Receiver: ready most cycles, short and occasional long stalls, calm stretches,
	// and the long hold on request.
	initial begin : receiver
		int stall_left;
		int hold_served;
		int cyc;
		int r;
		bit rx_quiet;
		stall_left  = 0;
		hold_served = 0;
		cyc         = 0;
		rx_quiet    = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 700 == 0)
				rx_quiet = ($urandom_range(0, 2) == 0);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				stall_left  = HOLD_CYCLES;
			end else if (stall_left == 0 && !rx_quiet) begin
				r = $urandom_range(0, 99);
				if (r >= 96)
					stall_left = $urandom_range(20, 100);
				else if (r >= 70)
					stall_left = $urandom_range(1, 4);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each delivered result with the oldest expectation.
	always @(posedge clk) begin : result_check
		tree_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: unexpected result found_key=%0d status=%0d",
						$time, found_key, status);
			end else begin
				want = expected_results.pop_front();
				if (found_key !== want.found || status !== want.st) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: result %0d expected found_key=%0d status=%0d, got %0d %0d",
							$time, results_seen, want.found, want.st, found_key, status);
				end
			end
		end
	end

	initial begin : main
		int i;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		action   <= ACT_TAKE;
		rank     <= '0;
		key      <= '0;
		amount   <= '0;
		for (i = 0; i < NUM_KEYS; i++)
			key_count[i] = 0;
		tree_total = 0;
		peak_total = 0;
		hot_keys[0] = '0;
		hot_keys[1] = KEY_W'(NUM_KEYS - 1);
		for (i = 2; i < HOT_KEYS; i++)
			hot_keys[i] = KEY_W'($urandom_range(0, NUM_KEYS - 1));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tree();
		test_extremes();
		test_random_traffic(180);
		test_output_stall();
		test_random_traffic(190);

		// Drain: wait for every expected result, then allow for a late extra one.
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d adds and %0d takes: %0d ok, %0d bad rank, %0d refused count.",
			adds_sent, takes_sent, ok_count, rank_fails, count_fails);
		$display("Checked %0d results, peak total %0d, %0d mismatches.",
			results_seen, peak_total, fault_count);
		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, clearing pass included.
	initial begin : watchdog
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
